// ===== sv/lps_pkg.sv =====
// lps_pkg: shared types and constants of the line pixel stepper
// coordinate width, command and step codes, registered item type
// no dependencies

package lps_pkg;

  // coordinate width inside the block, ports stay 16 bits
  localparam int COORD_BITS = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   acc_t;
  typedef logic [15:0]           color_t;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_NONE  = 2'd0,
    STEP_PLUS  = 2'd1,
    STEP_MINUS = 2'd3
  } step_t;

  // one command transaction after the input register
  typedef struct packed {
    cmd_t   command;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t pen_color;
  } lps_item_t;

endpackage

// ===== sv/lps_if.sv =====
// lps_if: valid/ready channel interfaces of the line pixel stepper
// command channel and pixel channel, each with source and sink modports
// no dependencies

interface lps_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] x_end;
  logic [15:0] y_end;
  logic [15:0] pen_color;

  modport source (output valid, command, x_start, y_start, x_end, y_end, pen_color,
                  input ready);
  modport sink (input valid, command, x_start, y_start, x_end, y_end, pen_color,
                output ready);
endinterface

interface lps_pix_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [15:0] pixel_color;
  logic        last;

  modport source (output valid, valid_res, pixel_x, pixel_y, pixel_color, last,
                  input ready);
  modport sink (input valid, valid_res, pixel_x, pixel_y, pixel_color, last,
                output ready);
endinterface

// ===== sv/lps_in_stage.sv =====
// lps_in_stage: input register of the line pixel stepper
// depends on lps_pkg and lps_cmd_if

module lps_in_stage
  import lps_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  lps_cmd_if.sink       in_ch,
  output logic          item_valid,
  output lps_item_t     item,
  input  logic          item_ready
);

  logic      valid_r;
  logic      valid_nxt;
  lps_item_t item_r;
  logic      load;

  // register is free when empty or when its transaction moves on
  assign in_ch.ready = !valid_r || item_ready;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture, coordinates cut to the internal width
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.command   <= cmd_t'(in_ch.command);
      item_r.x_start   <= in_ch.x_start[COORD_BITS-1:0];
      item_r.y_start   <= in_ch.y_start[COORD_BITS-1:0];
      item_r.x_end     <= in_ch.x_end[COORD_BITS-1:0];
      item_r.y_end     <= in_ch.y_end[COORD_BITS-1:0];
      item_r.pen_color <= in_ch.pen_color;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== sv/lps_step_core.sv =====
// lps_step_core: line state, error accumulators and pixel output register
// depends on lps_pkg and lps_pix_if

module lps_step_core
  import lps_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  lps_item_t     item,
  output logic          item_ready,
  lps_pix_if.source     out_ch
);

  // line state
  logic   active_r, active_nxt;
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  coord_t abs_dx_r, abs_dx_nxt;
  coord_t abs_dy_r, abs_dy_nxt;
  step_t  step_x_r, step_x_nxt;
  step_t  step_y_r, step_y_nxt;
  coord_t major_r, major_nxt;
  acc_t   err_x_r, err_x_nxt;
  acc_t   err_y_r, err_y_nxt;
  acc_t   done_r, done_nxt;
  color_t color_r, color_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  logic   res_valid_r, res_valid_nxt;
  coord_t pix_x_r, pix_x_nxt;
  coord_t pix_y_r, pix_y_nxt;
  color_t pix_color_r, pix_color_nxt;
  logic   last_r, last_nxt;

  logic   take;
  logic   is_last;
  acc_t   sum_x, sum_y;

  function automatic coord_t abs_diff(input coord_t from, input coord_t to);
    coord_t r;
    if (to > from) begin
      r = to - from;
    end else begin
      r = from - to;
    end
    return r;
  endfunction

  function automatic step_t step_dir(input coord_t from, input coord_t to);
    step_t s;
    if (to > from) begin
      s = STEP_PLUS;
    end else if (to == from) begin
      s = STEP_NONE;
    end else begin
      s = STEP_MINUS;
    end
    return s;
  endfunction

  function automatic coord_t apply_step(input coord_t c, input step_t s);
    coord_t r;
    unique case (s)
      STEP_PLUS:  r = c + coord_t'(1);
      STEP_MINUS: r = c - coord_t'(1);
      default:    r = c;
    endcase
    return r;
  endfunction

  // a transaction moves in when the output register is empty or drained
  assign item_ready = !out_valid_r || out_ch.ready;
  assign take       = item_valid && item_ready;

  // base state for this pixel, then one error step
  always_comb begin
    active_nxt    = active_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    abs_dx_nxt    = abs_dx_r;
    abs_dy_nxt    = abs_dy_r;
    step_x_nxt    = step_x_r;
    step_y_nxt    = step_y_r;
    major_nxt     = major_r;
    err_x_nxt     = err_x_r;
    err_y_nxt     = err_y_r;
    done_nxt      = done_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r;
    res_valid_nxt = res_valid_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    pix_color_nxt = pix_color_r;
    last_nxt      = last_r;
    is_last       = 1'b0;
    sum_x         = '0;
    sum_y         = '0;

    if (take) begin
      out_valid_nxt = 1'b1;
      if (item.command == CMD_START) begin
        abs_dx_nxt = abs_diff(item.x_start, item.x_end);
        abs_dy_nxt = abs_diff(item.y_start, item.y_end);
        step_x_nxt = step_dir(item.x_start, item.x_end);
        step_y_nxt = step_dir(item.y_start, item.y_end);
        major_nxt  = (abs_dx_nxt > abs_dy_nxt) ? abs_dx_nxt : abs_dy_nxt;
        cur_x_nxt  = item.x_start;
        cur_y_nxt  = item.y_start;
        err_x_nxt  = '0;
        err_y_nxt  = '0;
        done_nxt   = '0;
        color_nxt  = item.pen_color;
        active_nxt = 1'b1;
      end

      if (active_nxt) begin
        // emit the pixel at the base position
        is_last       = (done_nxt == ({1'b0, major_nxt} + acc_t'(1)));
        res_valid_nxt = 1'b1;
        pix_x_nxt     = cur_x_nxt;
        pix_y_nxt     = cur_y_nxt;
        pix_color_nxt = color_nxt;
        last_nxt      = is_last;

        sum_x = err_x_nxt + {1'b0, abs_dx_nxt};
        sum_y = err_y_nxt + {1'b0, abs_dy_nxt};
        err_x_nxt = sum_x;
        err_y_nxt = sum_y;
        if (sum_x > {1'b0, major_nxt}) begin
          err_x_nxt = sum_x - {1'b0, major_nxt};
          cur_x_nxt = apply_step(cur_x_nxt, step_x_nxt);
        end
        if (sum_y > {1'b0, major_nxt}) begin
          err_y_nxt = sum_y - {1'b0, major_nxt};
          cur_y_nxt = apply_step(cur_y_nxt, step_y_nxt);
        end
        done_nxt   = done_nxt + acc_t'(1);
        active_nxt = !is_last;
      end else begin
        // advance while idle
        res_valid_nxt = 1'b0;
        pix_x_nxt     = '0;
        pix_y_nxt     = '0;
        pix_color_nxt = '0;
        last_nxt      = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // line state and pixel payload
  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    abs_dx_r    <= abs_dx_nxt;
    abs_dy_r    <= abs_dy_nxt;
    step_x_r    <= step_x_nxt;
    step_y_r    <= step_y_nxt;
    major_r     <= major_nxt;
    err_x_r     <= err_x_nxt;
    err_y_r     <= err_y_nxt;
    done_r      <= done_nxt;
    color_r     <= color_nxt;
    res_valid_r <= res_valid_nxt;
    pix_x_r     <= pix_x_nxt;
    pix_y_r     <= pix_y_nxt;
    pix_color_r <= pix_color_nxt;
    last_r      <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.valid_res   = res_valid_r;
  assign out_ch.pixel_x     = 16'(pix_x_r);
  assign out_ch.pixel_y     = 16'(pix_y_r);
  assign out_ch.pixel_color = pix_color_r;
  assign out_ch.last        = last_r;

endmodule

// ===== sv/line_pixel_stepper.sv =====
// line_pixel_stepper: error-accumulating line rasterizer, top level
// depends on lps_pkg, lps_if, lps_in_stage and lps_step_core
//
//   channel   direction  transaction
//   in_ch     sink       start or advance command, endpoints, pen color
//   out_ch    source     one pixel: valid_res, x, y, color, last flag
//
// one pixel per clock sustained while commands arrive and out_ch does not stall;
// an accepted command is held in the input register, its pixel is then
// registered in the pixel register and leaves from there on out_ch
// the state step (two adds and compares) sits between the two registers
// reset clears the valid flags and the active flag; a line is idle after reset
// a stalled out_ch holds its pixel while in_ch still fills the input register

module line_pixel_stepper
  import lps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lps_cmd_if.sink   in_ch,
  lps_pix_if.source out_ch
);

  logic      item_valid;
  logic      item_ready;
  lps_item_t item;

  lps_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  lps_step_core u_step_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench of line_pixel_stepper, predicts every pixel transaction
// directed table, then random line sequences under three sender/receiver idle phases
// depends on lps_pkg, lps_if and line_pixel_stepper

module tb;
  import lps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 1350;
  localparam int DRAIN_LIMIT = 5000;

  // one command transaction as driven on the port
  typedef struct packed {
    cmd_t        command;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] pen_color;
  } cmd_item_t;

  // one pixel transaction
  typedef struct packed {
    logic        valid_res;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] pixel_color;
    logic        last;
  } pixel_t;

  // directed stimulus row, with an optional typed-in expectation
  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    pixel_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lps_cmd_if in_ch();
  lps_pix_if out_ch();

  line_pixel_stepper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted line state
  logic   ln_active;
  coord_t ln_x, ln_y;
  coord_t ln_dx, ln_dy;
  step_t  ln_sx, ln_sy;
  coord_t ln_len;
  acc_t   ln_ex, ln_ey;
  acc_t   ln_count;
  color_t ln_color;

  pixel_t    pending_pixels[$];
  stim_row_t directed_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int lines_started;
  int pixels_checked;
  int lines_finished;
  int idle_advances;
  int errors;

  pixel_t got_px;
  pixel_t want_px;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // absolute span and step direction of one axis
  function automatic void axis_span(input coord_t from, input coord_t to,
                                    output coord_t mag, output step_t dir);
    if (to > from) begin
      mag = to - from;
      dir = STEP_PLUS;
    end else if (to == from) begin
      mag = '0;
      dir = STEP_NONE;
    end else begin
      mag = from - to;
      dir = STEP_MINUS;
    end
  endfunction

  function automatic coord_t step_coord(input coord_t c, input step_t dir);
    coord_t r;
    case (dir)
      STEP_PLUS:  r = c + coord_t'(1);
      STEP_MINUS: r = c - coord_t'(1);
      default:    r = c;
    endcase
    return r;
  endfunction

  // next pixel of the line stepper for one accepted command, updates line state
  function automatic pixel_t trace_pixel(input cmd_item_t it);
    pixel_t p;
    logic   fin;
    p = '0;
    if (it.command == CMD_START) begin
      axis_span(coord_t'(it.x_start), coord_t'(it.x_end), ln_dx, ln_sx);
      axis_span(coord_t'(it.y_start), coord_t'(it.y_end), ln_dy, ln_sy);
      ln_len    = (ln_dx > ln_dy) ? ln_dx : ln_dy;
      ln_x      = coord_t'(it.x_start);
      ln_y      = coord_t'(it.y_start);
      ln_ex     = '0;
      ln_ey     = '0;
      ln_count  = '0;
      ln_color  = it.pen_color;
      ln_active = 1'b1;
    end
    if (ln_active) begin
      fin           = (ln_count == acc_t'(ln_len) + acc_t'(1));
      p.valid_res   = 1'b1;
      p.pixel_x     = 16'(ln_x);
      p.pixel_y     = 16'(ln_y);
      p.pixel_color = ln_color;
      p.last        = fin;
      // accumulate error, step the coordinate on overflow past the distance
      ln_ex = ln_ex + acc_t'(ln_dx);
      ln_ey = ln_ey + acc_t'(ln_dy);
      if (ln_ex > acc_t'(ln_len)) begin
        ln_ex = ln_ex - acc_t'(ln_len);
        ln_x  = step_coord(ln_x, ln_sx);
      end
      if (ln_ey > acc_t'(ln_len)) begin
        ln_ey = ln_ey - acc_t'(ln_len);
        ln_y  = step_coord(ln_y, ln_sy);
      end
      ln_count = ln_count + acc_t'(1);
      if (fin) ln_active = 1'b0;
    end
    return p;
  endfunction

  function automatic pixel_t pix(input logic v, input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] c, input logic l);
    pixel_t p;
    p.valid_res   = v;
    p.pixel_x     = x;
    p.pixel_y     = y;
    p.pixel_color = c;
    p.last        = l;
    return p;
  endfunction

  function automatic stim_row_t make_row(input cmd_t cmd, input logic [15:0] xs,
                                         input logic [15:0] ys, input logic [15:0] xe,
                                         input logic [15:0] ye, input logic [15:0] col,
                                         input logic typed, input pixel_t want);
    stim_row_t r;
    r.item.command   = cmd;
    r.item.x_start   = xs;
    r.item.y_start   = ys;
    r.item.x_end     = xe;
    r.item.y_end     = ye;
    r.item.pen_color = col;
    r.typed          = typed;
    r.want           = want;
    return r;
  endfunction

  function automatic cmd_item_t random_item(input cmd_t cmd);
    cmd_item_t it;
    it.command   = cmd;
    it.x_start   = 16'($urandom);
    it.y_start   = 16'($urandom);
    it.x_end     = 16'($urandom);
    it.y_end     = 16'($urandom);
    it.pen_color = 16'($urandom);
    return it;
  endfunction

  // drive one command transaction, record the expected pixel on acceptance
  task automatic send_cmd(input cmd_item_t it, input logic typed, input pixel_t want);
    pixel_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= it.command;
    in_ch.x_start   <= it.x_start;
    in_ch.y_start   <= it.y_start;
    in_ch.x_end     <= it.x_end;
    in_ch.y_end     <= it.y_end;
    in_ch.pen_color <= it.pen_color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = trace_pixel(it);
    pending_pixels.push_back(typed ? want : p);
    items_sent++;
    if (it.command == CMD_START) lines_started++;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // pixel monitor and checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_px = pix(out_ch.valid_res, out_ch.pixel_x, out_ch.pixel_y,
                   out_ch.pixel_color, out_ch.last);
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel transaction, expected none, got %h",
                 $time, got_px);
        errors++;
      end else begin
        want_px = pending_pixels.pop_front();
        check_field("valid_res", 16'(want_px.valid_res), 16'(got_px.valid_res));
        check_field("pixel_x", want_px.pixel_x, got_px.pixel_x);
        check_field("pixel_y", want_px.pixel_y, got_px.pixel_y);
        check_field("pixel_color", want_px.pixel_color, got_px.pixel_color);
        check_field("last", 16'(want_px.last), 16'(got_px.last));
      end
      pixels_checked++;
      if (got_px.valid_res && got_px.last) lines_finished++;
      if (!got_px.valid_res) idle_advances++;
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d pixels still pending", $time, pending_pixels.size());
    $display("line_pixel_stepper test failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    cmd_item_t it;
    int        stim_limit;
    int        kind;
    int        budget;
    int        waited;
    logic [15:0] dx;
    logic [15:0] dy;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_START;
    in_ch.x_start   = '0;
    in_ch.y_start   = '0;
    in_ch.x_end     = '0;
    in_ch.y_end     = '0;
    in_ch.pen_color = '0;
    out_ch.ready    = 1'b0;
    ln_active = 1'b0;
    ln_x = '0; ln_y = '0; ln_dx = '0; ln_dy = '0;
    ln_sx = STEP_NONE; ln_sy = STEP_NONE;
    ln_len = '0; ln_ex = '0; ln_ey = '0; ln_count = '0; ln_color = '0;
    items_sent = 0; lines_started = 0; pixels_checked = 0;
    lines_finished = 0; idle_advances = 0; errors = 0;
    send_idle_pct = 21;
    recv_idle_pct = 73;

    // advance while idle, zero-length lines at both extremes, short lines,
    // a long line abandoned by a new start, a line run to its end, then idle again
    directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                     pix(1'b0, 16'h0, 16'h0, 16'h0, 1'b0)));
    directed_rows.push_back(make_row(CMD_START, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                     pix(1'b1, 16'h0, 16'h0, 16'h0, 1'b0)));
    directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                     pix(1'b1, 16'h0, 16'h0, 16'h0, 1'b1)));
    directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                     pix(1'b0, 16'h0, 16'h0, 16'h0, 1'b0)));
    directed_rows.push_back(make_row(CMD_START, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                     16'hffff, 1'b1,
                                     pix(1'b1, 16'hffff, 16'hffff, 16'hffff, 1'b0)));
    directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                     pix(1'b1, 16'hffff, 16'hffff, 16'hffff, 1'b1)));
    directed_rows.push_back(make_row(CMD_START, 16'd0, 16'd0, 16'd3, 16'd1, 16'h1234,
                                     1'b0, '0));
    repeat (4) directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0,
                                                16'h0, 1'b0, '0));
    directed_rows.push_back(make_row(CMD_START, 16'hffff, 16'h0, 16'h0, 16'hffff, 16'ha5a5,
                                     1'b0, '0));
    repeat (3) directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0,
                                                16'h0, 1'b0, '0));
    directed_rows.push_back(make_row(CMD_START, 16'd10, 16'd20, 16'd7, 16'd25, 16'h5a5a,
                                     1'b0, '0));
    repeat (6) directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0,
                                                16'h0, 1'b0, '0));
    directed_rows.push_back(make_row(CMD_ADVANCE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1,
                                     pix(1'b0, 16'h0, 16'h0, 16'h0, 1'b0)));

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // random line sequences: mostly lines walked to the end, some abandoned,
    // some far-reaching endpoints, and stray advances
    stim_limit = items_sent + RAND_ITEMS;
    while (items_sent < stim_limit) begin
      if (items_sent < stim_limit - (2 * RAND_ITEMS) / 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 73;
      end else if (items_sent < stim_limit - RAND_ITEMS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        send_cmd(random_item(CMD_ADVANCE), 1'b0, '0);
      end else begin
        it = random_item(CMD_START);
        if (kind >= 20) begin
          dx = 16'($urandom_range(0, 24));
          dy = 16'($urandom_range(0, 24));
          it.x_end = $urandom_range(0, 1) ? it.x_start + dx : it.x_start - dx;
          it.y_end = $urandom_range(0, 1) ? it.y_start + dy : it.y_start - dy;
        end
        send_cmd(it, 1'b0, '0);
        budget = (kind < 30) ? $urandom_range(0, 8) : 60;
        while (ln_active && budget > 0 && items_sent < stim_limit) begin
          send_cmd(random_item(CMD_ADVANCE), 1'b0, '0);
          budget--;
        end
      end
    end
    in_ch.valid   <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // drain outstanding pixels, then keep watching for stray output
    waited = 0;
    while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived, oldest %h", $time,
               pending_pixels.size(), pending_pixels[0]);
      errors++;
    end

    $display("%0d commands sent, %0d lines started, %0d lines ended with the last flag",
             items_sent, lines_started, lines_finished);
    $display("%0d pixel transactions checked, %0d advances while idle, %0d mismatches",
             pixels_checked, idle_advances, errors);
    if (errors == 0) begin
      $display("line_pixel_stepper test passed");
    end else begin
      $display("line_pixel_stepper test failed");
    end
    $finish;
  end

endmodule

// ===== line_pixel_stepper.f =====
sv/lps_pkg.sv
sv/lps_if.sv
sv/lps_in_stage.sv
sv/lps_step_core.sv
sv/line_pixel_stepper.sv
tb/tb.sv
